// ===== hdl/mm4_pkg.sv =====
// mm4_pkg: shared types and constants for the 4x4 matrix multiply unit
// no dependencies; used by the channel interfaces and imported by the top level

package mm4_pkg;

	localparam int DIM_BITS  = 2;
	localparam int ADDR_BITS = 2 * DIM_BITS;
	localparam int VALUE_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * VALUE_W;
	localparam int ACC_W     = PROD_W + DIM_BITS;

	typedef logic [DIM_BITS-1:0]       idx_t;
	typedef logic [ADDR_BITS-1:0]      addr_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [1:0] {
		MODE_LOAD_LEFT  = 2'd0,
		MODE_LOAD_RIGHT = 2'd1,
		MODE_PRODUCT    = 2'd2
	} mode_t;

	localparam idx_t IDX_LAST = '1;

	// control carried alongside the multiply pipeline
	typedef struct packed {
		logic vld;
		idx_t col;
		idx_t row;
		logic k_first;
		logic k_last;
	} mac_ctl_t;

	// floor shift by the fraction width and saturate to the value range
	function automatic value_t sat_shift(input logic signed [ACC_W-1:0] sum);
		logic [ACC_W-FRAC_BITS-VALUE_W:0] top;
		begin
			top = sum[ACC_W-1:FRAC_BITS+VALUE_W-1];
			if (top == '0 || top == '1) begin
				sat_shift = sum[FRAC_BITS+VALUE_W-1:FRAC_BITS];
			end else if (sum[ACC_W-1]) begin
				sat_shift = {1'b1, {(VALUE_W-1){1'b0}}};
			end else begin
				sat_shift = {1'b0, {(VALUE_W-1){1'b1}}};
			end
		end
	endfunction

endpackage

// ===== hdl/mm4_if.sv =====
// mm4_if: valid/ready channel interfaces for the 4x4 matrix multiply unit
// depends on mm4_pkg for field types

interface mm4_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	mm4_pkg::idx_t     col_index;
	mm4_pkg::idx_t     row_index;
	mm4_pkg::value_t   element_value;

	modport source (output valid, mode, col_index, row_index, element_value, input ready);
	modport sink   (input valid, mode, col_index, row_index, element_value, output ready);
endinterface

interface mm4_out_if;
	logic              valid;
	logic              ready;
	mm4_pkg::idx_t     out_col;
	mm4_pkg::idx_t     out_row;
	mm4_pkg::value_t   product_value;
	logic              last;

	modport source (output valid, out_col, out_row, product_value, last, input ready);
	modport sink   (input valid, out_col, out_row, product_value, last, output ready);
endinterface

// ===== hdl/matrix4_multiply_unit.sv =====
// matrix4_multiply_unit: column-major 4x4 Q16.16 matrix product over two 16-entry memories
// depends on mm4_pkg and the channel interfaces in mm4_if
//
//   channel  dir  payload                                          beat means
//   item     in   mode, col_index, row_index, element_value        one load or one product request
//   result   out  out_col, out_row, product_value, last            one product element
//
// a load writes one entry; a product request issues 64 multiply-accumulates, one per
// cycle through the shared multiplier while the result is not stalled, four per element,
// until the last element is registered.
// a stalled result freezes the whole multiply pipeline; no new item is taken while
// reads are still being issued. reset clears the per-entry valid bits, so both
// matrices read as zero until written; no clearing pass is needed.

module matrix4_multiply_unit (
	input  logic       clk,
	input  logic       arst_n,
	mm4_in_if.sink     item,
	mm4_out_if.source  result
);
	import mm4_pkg::*;

	value_t                   left_mem  [2**ADDR_BITS];
	value_t                   right_mem [2**ADDR_BITS];
	logic [2**ADDR_BITS-1:0]  left_ok_q;
	logic [2**ADDR_BITS-1:0]  right_ok_q;

	logic                     busy_q;
	logic [3*DIM_BITS-1:0]    cnt_q;
	idx_t                     cnt_j, cnt_i, cnt_k;
	addr_t                    left_addr, right_addr;

	value_t                   left_s1, right_s1;
	mac_ctl_t                 ctl_s1, ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q, acc_sum;

	logic                     out_vld_q;
	idx_t                     out_col_q, out_row_q;
	value_t                   out_val_q;
	logic                     out_last_q;

	logic                     adv;
	logic                     take;

	assign take = item.valid && item.ready;
	assign item.ready = !busy_q;
	assign adv = !out_vld_q || result.ready;

	assign {cnt_j, cnt_i, cnt_k} = cnt_q;
	assign left_addr  = {cnt_k, cnt_i};
	assign right_addr = {cnt_j, cnt_k};

	// memory writes on load beats
	always_ff @(posedge clk) begin
		if (take && item.mode == MODE_LOAD_LEFT) begin
			left_mem[{item.col_index, item.row_index}] <= item.element_value;
		end
		if (take && item.mode == MODE_LOAD_RIGHT) begin
			right_mem[{item.col_index, item.row_index}] <= item.element_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_ok_q  <= '0;
			right_ok_q <= '0;
		end else if (take) begin
			if (item.mode == MODE_LOAD_LEFT) begin
				left_ok_q[{item.col_index, item.row_index}] <= 1'b1;
			end
			if (item.mode == MODE_LOAD_RIGHT) begin
				right_ok_q[{item.col_index, item.row_index}] <= 1'b1;
			end
		end
	end

	// synchronous reads, entries never written read as zero
	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			left_s1  <= left_ok_q[left_addr]   ? left_mem[left_addr]   : '0;
			right_s1 <= right_ok_q[right_addr] ? right_mem[right_addr] : '0;
		end
	end

	// issue sequencer: cnt walks column j, row i, term k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take && item.mode == MODE_PRODUCT) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && adv) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1.vld     <= busy_q;
			ctl_s1.col     <= cnt_j;
			ctl_s1.row     <= cnt_i;
			ctl_s1.k_first <= (cnt_k == '0);
			ctl_s1.k_last  <= (cnt_k == IDX_LAST);
			ctl_s2         <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= left_s1 * right_s1;
		end
	end

	// exact sum of four products
	assign acc_sum = (ctl_s2.k_first ? '0 : acc_q) + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.vld) begin
			acc_q <= acc_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= ctl_s2.vld && ctl_s2.k_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.vld && ctl_s2.k_last) begin
			out_col_q  <= ctl_s2.col;
			out_row_q  <= ctl_s2.row;
			out_val_q  <= sat_shift(acc_sum);
			out_last_q <= (ctl_s2.col == IDX_LAST) && (ctl_s2.row == IDX_LAST);
		end
	end

	assign result.valid         = out_vld_q;
	assign result.out_col       = out_col_q;
	assign result.out_row       = out_row_q;
	assign result.product_value = out_val_q;
	assign result.last          = out_last_q;

	a_product_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.mode == MODE_PRODUCT) |=> (busy_q && cnt_q == '0))
		else $error("product request did not start the sequencer");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !adv) |=> $stable(cnt_q))
		else $error("sequencer advanced during an output stall");

	a_wrap_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (cnt_q == '0 && ctl_s1.vld && ctl_s1.k_last))
		else $error("sequencer stopped before the last term");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_last_q) |-> (out_col_q == IDX_LAST && out_row_q == IDX_LAST))
		else $error("last flag on an element other than the final one");

endmodule

// ===== tb/tb_matrix4_multiply_unit.sv =====
`timescale 1ns / 100ps
// tb_matrix4_multiply_unit: self-checking bench for the 4x4 Q16.16 matrix multiply unit
// needs mm4_pkg, mm4_if and matrix4_multiply_unit; a scoreboard class predicts each product

module tb_matrix4_multiply_unit;
	import mm4_pkg::*;

	localparam logic [1:0] MODE_UNUSED     = 2'd3;
	localparam value_t     Q_MAX           = 32'sh7FFF_FFFF;
	localparam value_t     Q_MIN           = 32'sh8000_0000;
	localparam value_t     Q_ONE           = 32'sh0001_0000;
	localparam int         QUIET_LIMIT     = 5000;
	localparam int         HOLD_OFF_CYCLES = 400;
	localparam int         DRAIN_TAIL      = 100;
	localparam int         ITEM_TARGET     = 250;
	localparam int         PRINT_CAP       = 50;

	typedef struct {
		idx_t   col;
		idx_t   row;
		value_t val;
		logic   last;
	} element_t;

	class mm4_product_checker;
		value_t   left_mem[16];
		value_t   right_mem[16];
		element_t due[$];
		int       errors;

		function new();
			foreach (left_mem[a]) begin
				left_mem[a]  = '0;
				right_mem[a] = '0;
			end
			errors = 0;
		endfunction

		// exact four-term dot product, floor shift, clamp to 32 bits
		function value_t element_of(int col, int row);
			logic signed [65:0] acc;
			logic signed [63:0] prod;
			logic signed [65:0] scaled;
			int k;
			acc = '0;
			for (k = 0; k < 4; k++) begin
				prod = left_mem[k*4+row] * right_mem[col*4+k];
				acc  = acc + prod;
			end
			scaled = acc >>> FRAC_BITS;
			if (scaled > Q_MAX)
				return Q_MAX;
			else if (scaled < Q_MIN)
				return Q_MIN;
			return scaled[31:0];
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		function void note_item(logic [1:0] m, idx_t c, idx_t r, value_t v);
			element_t e;
			int j, i;
			case (m)
				MODE_LOAD_LEFT:  left_mem[{c, r}]  = v;
				MODE_LOAD_RIGHT: right_mem[{c, r}] = v;
				MODE_PRODUCT: begin
					for (j = 0; j < 4; j++) begin
						for (i = 0; i < 4; i++) begin
							e.col  = idx_t'(j);
							e.row  = idx_t'(i);
							e.val  = element_of(j, i);
							e.last = (j == 3 && i == 3);
							due.push_back(e);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task check_element(idx_t c, idx_t r, value_t v, logic l);
			element_t e;
			if (due.size() == 0) begin
				report($sformatf("unexpected element col %0d row %0d value %h", c, r, v));
				return;
			end
			e = due.pop_front();
			if (c !== e.col)
				report($sformatf("out_col %0d, want %0d", c, e.col));
			if (r !== e.row)
				report($sformatf("out_row %0d, want %0d", r, e.row));
			if (v !== e.val)
				report($sformatf("product_value %h at col %0d row %0d, want %h",
					v, e.col, e.row, e.val));
			if (l !== e.last)
				report($sformatf("last %b at col %0d row %0d, want %b", l, e.col, e.row, e.last));
		endtask

		function int pending();
			return due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mm4_in_if  item_if ();
	mm4_out_if result_if ();

	matrix4_multiply_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	mm4_product_checker chk;
	int   quiet_cycles = 0;
	int   items_sent;
	int   burst_left;
	logic hold_off_req;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sample both channels on the rising edge; inputs only move on the falling edge
	always @(posedge clk) begin
		if (item_if.valid && item_if.ready)
			chk.note_item(item_if.mode, item_if.col_index, item_if.row_index,
				item_if.element_value);
		if (result_if.valid && result_if.ready)
			chk.check_element(result_if.out_col, result_if.out_row, result_if.product_value,
				result_if.last);
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// receiver: stretches of differing readiness, plus one long hold-off on request
	initial begin : result_sink
		int len;
		int kind;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			len  = $urandom_range(1, 60);
			kind = $urandom_range(0, 3);
			repeat (len) begin
				if (hold_off_req) begin
					result_if.ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_req = 1'b0;
				end else begin
					case (kind)
						0:       result_if.ready <= 1'b1;
						1:       result_if.ready <= ($urandom_range(0, 3) != 0);
						2:       result_if.ready <= ($urandom_range(0, 3) == 0);
						default: result_if.ready <= ~result_if.ready;
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// called on a falling edge; returns on the falling edge after the beat
	task automatic send_item(logic [1:0] m, idx_t c, idx_t r, value_t v);
		item_if.valid         <= 1'b1;
		item_if.mode          <= m;
		item_if.col_index     <= c;
		item_if.row_index     <= r;
		item_if.element_value <= v;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic offer(logic [1:0] m, idx_t c, idx_t r, value_t v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		send_item(m, c, r, v);
		if (m != MODE_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		item_if.valid <= 1'b0;
		while (chk.pending() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	function automatic value_t pick_value(int cls);
		int t;
		case (cls)
			0: begin
				t = int'($urandom_range(0, 262143)) - 131072;
				return t;
			end
			1: return $urandom;
			2: begin
				case ($urandom_range(0, 5))
					0:       return Q_MIN;
					1:       return Q_MAX;
					2:       return '0;
					3:       return -1;
					4:       return 1;
					default: return $urandom;
				endcase
			end
			default: begin
				t = int'($urandom_range(0, 33554431)) - 16777216;
				return t;
			end
		endcase
	endfunction

	function automatic idx_t any_idx();
		return idx_t'($urandom_range(0, 3));
	endfunction

	initial begin : stimulus
		int set_no;
		int s;
		int t;
		int tmp;
		int cls;
		int n;
		int addr;
		int slot[32];
		logic [1:0] m;

		arst_n                = 1'b0;
		item_if.valid         = 1'b0;
		item_if.mode          = MODE_LOAD_LEFT;
		item_if.col_index     = '0;
		item_if.row_index     = '0;
		item_if.element_value = '0;
		items_sent            = 0;
		burst_left            = 0;
		hold_off_req          = 1'b0;
		chk = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// product of the cleared stores, with junk in the ignored fields
		offer(MODE_PRODUCT, 2'd3, 2'd1, 32'sh5A5A_A5A5);
		offer(MODE_UNUSED, 2'd0, 2'd0, Q_MAX);
		// element (0,0) overflows upward
		for (s = 0; s < 4; s++) begin
			offer(MODE_LOAD_LEFT, idx_t'(s), 2'd0, Q_MAX);
			offer(MODE_LOAD_RIGHT, 2'd0, idx_t'(s), Q_MAX);
		end
		offer(MODE_PRODUCT, 2'd0, 2'd0, '0);
		// then downward
		for (s = 0; s < 4; s++)
			offer(MODE_LOAD_LEFT, idx_t'(s), 2'd0, Q_MIN);
		offer(MODE_PRODUCT, 2'd1, 2'd2, Q_MIN);
		// unused mode must not land in the store
		offer(MODE_UNUSED, 2'd2, 2'd2, Q_MAX);
		// -1 lsb times 1 lsb floors to -1; one times one stays exact
		offer(MODE_LOAD_LEFT, 2'd3, 2'd3, -1);
		offer(MODE_LOAD_RIGHT, 2'd3, 2'd3, 1);
		offer(MODE_LOAD_LEFT, 2'd1, 2'd1, Q_ONE);
		offer(MODE_LOAD_RIGHT, 2'd1, 2'd1, Q_ONE);
		offer(MODE_PRODUCT, 2'd2, 2'd3, Q_ONE);
		wait_drained();

		set_no = 0;
		while (items_sent < ITEM_TARGET) begin
			if (set_no == 2) begin
				// receiver stalls for a long while so the pipeline backs up
				hold_off_req = 1'b1;
				repeat (3) offer(MODE_PRODUCT, any_idx(), any_idx(), $urandom);
			end
			if (set_no == 5)
				wait_drained();
			if ($urandom_range(0, 9) < 7) begin
				// full reload of both matrices in random order, then a product
				cls = $urandom_range(0, 3);
				for (s = 0; s < 32; s++)
					slot[s] = s;
				for (s = 31; s > 0; s--) begin
					t       = $urandom_range(0, s);
					tmp     = slot[s];
					slot[s] = slot[t];
					slot[t] = tmp;
				end
				for (s = 0; s < 32; s++) begin
					if ($urandom_range(0, 9) == 0)
						offer(MODE_UNUSED, any_idx(), any_idx(), $urandom);
					addr = slot[s] % 16;
					offer((slot[s] < 16) ? MODE_LOAD_LEFT : MODE_LOAD_RIGHT,
						idx_t'(addr / 4), idx_t'(addr % 4), pick_value(cls));
				end
				offer(MODE_PRODUCT, any_idx(), any_idx(), $urandom);
			end else begin
				// scattered updates of any kind, sometimes followed by a product
				n = $urandom_range(1, 6);
				repeat (n) begin
					m = 2'($urandom_range(0, 3));
					offer(m, any_idx(), any_idx(), pick_value($urandom_range(0, 3)));
				end
				if ($urandom_range(0, 2) == 0)
					offer(MODE_PRODUCT, any_idx(), any_idx(), $urandom);
			end
			set_no++;
		end

		wait_drained();
		repeat (DRAIN_TAIL) @(negedge clk);
		if (chk.pending() != 0)
			chk.report($sformatf("%0d product elements never arrived", chk.pending()));
		if (chk.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
